// ===== hdl/segx_pkg.sv =====
// Package for the segment intersection point block.
// Holds the coordinate widths, derived arithmetic widths and the
// pipeline side-band type; depends on nothing.
package segx_pkg;

  localparam int CB = 18;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;
  localparam int ML = CW - DW;
  localparam int MW = DW + CW;
  localparam int NW = MW + 2;
  localparam int D2W = CW + 1;
  localparam int QB = CB + 2;
  localparam int EW = QB + 1;

  typedef struct packed {
    logic valid;
    logic hit;
    logic use_div;
    logic neg_x;
    logic neg_y;
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
  } side_t;

endpackage

// ===== hdl/segment_intersection_point.sv =====
// Top level of the segment intersection point block.
// Uses segx_pkg for widths and the side-band type carried down the pipeline.
//
// The block takes one segment pair in every clock cycle and never raises busy.
// Each word comes out on hit, meet_x and meet_y with done high for one cycle,
// after six arithmetic stages (differences, products, cross products, meeting
// test, split multiply, dividend setup), one stage for each of the 20 quotient
// bits of the rounding divider, and one output stage. The receiver cannot
// stall the block, so results are never held back.
module segment_intersection_point
  import segx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CB-1:0] a_start_x,
  input  logic signed [CB-1:0] a_start_y,
  input  logic signed [CB-1:0] a_end_x,
  input  logic signed [CB-1:0] a_end_y,
  input  logic signed [CB-1:0] b_start_x,
  input  logic signed [CB-1:0] b_start_y,
  input  logic signed [CB-1:0] b_end_x,
  input  logic signed [CB-1:0] b_end_y,
  output logic                 done,
  output logic                 hit,
  output logic signed [CB-1:0] meet_x,
  output logic signed [CB-1:0] meet_y
);

  function automatic logic between(logic signed [CB-1:0] v, logic signed [CB-1:0] p,
                                   logic signed [CB-1:0] q);
    between = (v >= p && v <= q) || (v >= q && v <= p);
  endfunction

  // Stage 1: differences and bounding box tests.
  logic                 v1;
  logic signed [CB-1:0] c1_ax, c1_ay, c1_ex, c1_ey, c1_bx, c1_by, c1_fx, c1_fy;
  logic signed [DW-1:0] fdx, fdy, sdx, sdy, dbax, dbay, dbex, dbey, dabx, daby;
  logic [3:0]           box1;

  // Stage 2: products.
  logic                 v2;
  logic signed [CB-1:0] c2_ax, c2_ay, c2_ex, c2_ey, c2_bx, c2_by, c2_fx, c2_fy;
  logic signed [DW-1:0] fdx2, fdy2;
  logic [3:0]           box2;
  logic signed [PW-1:0] p0a, p0b, p1a, p1b, p2a, p2b, p3a, p3b, pda, pdb;

  // Stage 3: cross products.
  logic                 v3;
  logic signed [CB-1:0] c3_ax, c3_ay, c3_ex, c3_ey, c3_bx, c3_by, c3_fx, c3_fy;
  logic signed [DW-1:0] fdx3, fdy3;
  logic [3:0]           box3;
  logic signed [CW-1:0] cr0, cr1, cr2, cr3, den;

  // Stage 4: meeting test and magnitudes.
  side_t                m4;
  logic [DW-1:0]        afx, afy;
  logic [CW-1:0]        anum, aden;

  // Stage 5: split products.
  side_t                m5;
  logic [PW-1:0]        phx, phy;
  logic [DW+ML-1:0]     plx, ply;
  logic [CW-1:0]        aden5;

  // Divider stages.
  side_t                dm [0:QB];
  logic [NW-1:0]        rx [0:QB];
  logic [NW-1:0]        ry [0:QB];
  logic [QB-1:0]        qx [0:QB];
  logic [QB-1:0]        qy [0:QB];
  logic [D2W-1:0]       dd [0:QB];
  logic [NW-1:0]        shd [0:QB-1];
  logic [QB-1:0]        gex, gey;

  logic z0, z1, z2, z3, on_bsa, on_bea, on_asb, on_aeb, proper, meet, den_nz;
  logic [MW-1:0] prx, pry;
  logic signed [EW-1:0] qsx, qsy, sumx, sumy;

  assign busy = 1'b0;

  always_comb begin
    z0 = (cr0 == '0);
    z1 = (cr1 == '0);
    z2 = (cr2 == '0);
    z3 = (cr3 == '0);
    on_bsa = z0 && box3[0];
    on_bea = z1 && box3[1];
    on_asb = z2 && box3[2];
    on_aeb = z3 && box3[3];
    proper = ((!cr0[CW-1] && !z0 && cr1[CW-1]) || (cr0[CW-1] && !cr1[CW-1] && !z1)) &&
             ((!cr2[CW-1] && !z2 && cr3[CW-1]) || (cr2[CW-1] && !cr3[CW-1] && !z3));
    meet = proper || on_bsa || on_bea || on_asb || on_aeb;
    den_nz = (den != '0);
    prx = (MW'(phx) << ML) + MW'(plx);
    pry = (MW'(phy) << ML) + MW'(ply);
    for (int k = 0; k < QB; k++) begin
      shd[k] = NW'(dd[k]) << (QB - 1 - k);
      gex[k] = rx[k] >= shd[k];
      gey[k] = ry[k] >= shd[k];
    end
    qsx = dm[QB].neg_x ? -$signed({1'b0, qx[QB]}) : $signed({1'b0, qx[QB]});
    qsy = dm[QB].neg_y ? -$signed({1'b0, qy[QB]}) : $signed({1'b0, qy[QB]});
    sumx = EW'(dm[QB].ax) + qsx;
    sumy = EW'(dm[QB].ay) + qsy;
  end

  always_ff @(posedge clk) begin
    c1_ax <= a_start_x; c1_ay <= a_start_y; c1_ex <= a_end_x; c1_ey <= a_end_y;
    c1_bx <= b_start_x; c1_by <= b_start_y; c1_fx <= b_end_x; c1_fy <= b_end_y;
    fdx  <= DW'(a_end_x) - DW'(a_start_x);
    fdy  <= DW'(a_end_y) - DW'(a_start_y);
    sdx  <= DW'(b_end_x) - DW'(b_start_x);
    sdy  <= DW'(b_end_y) - DW'(b_start_y);
    dbax <= DW'(b_start_x) - DW'(a_start_x);
    dbay <= DW'(b_start_y) - DW'(a_start_y);
    dbex <= DW'(b_end_x) - DW'(a_start_x);
    dbey <= DW'(b_end_y) - DW'(a_start_y);
    dabx <= DW'(a_end_x) - DW'(b_start_x);
    daby <= DW'(a_end_y) - DW'(b_start_y);
    box1[0] <= between(b_start_x, a_start_x, a_end_x) && between(b_start_y, a_start_y, a_end_y);
    box1[1] <= between(b_end_x, a_start_x, a_end_x) && between(b_end_y, a_start_y, a_end_y);
    box1[2] <= between(a_start_x, b_start_x, b_end_x) && between(a_start_y, b_start_y, b_end_y);
    box1[3] <= between(a_end_x, b_start_x, b_end_x) && between(a_end_y, b_start_y, b_end_y);

    c2_ax <= c1_ax; c2_ay <= c1_ay; c2_ex <= c1_ex; c2_ey <= c1_ey;
    c2_bx <= c1_bx; c2_by <= c1_by; c2_fx <= c1_fx; c2_fy <= c1_fy;
    fdx2 <= fdx; fdy2 <= fdy; box2 <= box1;
    p0a <= PW'(fdx) * PW'(dbay);
    p0b <= PW'(fdy) * PW'(dbax);
    p1a <= PW'(fdx) * PW'(dbey);
    p1b <= PW'(fdy) * PW'(dbex);
    p2a <= PW'(sdy) * PW'(dbax);
    p2b <= PW'(sdx) * PW'(dbay);
    p3a <= PW'(sdx) * PW'(daby);
    p3b <= PW'(sdy) * PW'(dabx);
    pda <= PW'(fdx) * PW'(sdy);
    pdb <= PW'(fdy) * PW'(sdx);

    c3_ax <= c2_ax; c3_ay <= c2_ay; c3_ex <= c2_ex; c3_ey <= c2_ey;
    c3_bx <= c2_bx; c3_by <= c2_by; c3_fx <= c2_fx; c3_fy <= c2_fy;
    fdx3 <= fdx2; fdy3 <= fdy2; box3 <= box2;
    cr0 <= CW'(p0a) - CW'(p0b);
    cr1 <= CW'(p1a) - CW'(p1b);
    cr2 <= CW'(p2a) - CW'(p2b);
    cr3 <= CW'(p3a) - CW'(p3b);
    den <= CW'(pda) - CW'(pdb);

    m4.hit <= meet && (den_nz || on_asb || on_aeb || on_bsa || on_bea);
    m4.use_div <= meet && den_nz;
    m4.neg_x <= fdx3[DW-1] ^ cr2[CW-1] ^ den[CW-1];
    m4.neg_y <= fdy3[DW-1] ^ cr2[CW-1] ^ den[CW-1];
    m4.ax <= c3_ax;
    m4.ay <= c3_ay;
    if (on_asb) begin
      m4.px <= c3_ax; m4.py <= c3_ay;
    end else if (on_aeb) begin
      m4.px <= c3_ex; m4.py <= c3_ey;
    end else if (on_bsa) begin
      m4.px <= c3_bx; m4.py <= c3_by;
    end else begin
      m4.px <= c3_fx; m4.py <= c3_fy;
    end
    afx  <= fdx3[DW-1] ? DW'(-fdx3) : DW'(fdx3);
    afy  <= fdy3[DW-1] ? DW'(-fdy3) : DW'(fdy3);
    anum <= cr2[CW-1] ? CW'(-cr2) : CW'(cr2);
    aden <= den[CW-1] ? CW'(-den) : CW'(den);

    phx <= PW'(afx) * PW'(anum[CW-1:ML]);
    phy <= PW'(afy) * PW'(anum[CW-1:ML]);
    plx <= (DW+ML)'(afx) * (DW+ML)'(anum[ML-1:0]);
    ply <= (DW+ML)'(afy) * (DW+ML)'(anum[ML-1:0]);
    aden5 <= aden;

    rx[0] <= (NW'(prx) << 1) + NW'(aden5) - NW'(m5.neg_x);
    ry[0] <= (NW'(pry) << 1) + NW'(aden5) - NW'(m5.neg_y);
    qx[0] <= '0;
    qy[0] <= '0;
    dd[0] <= {aden5, 1'b0};

    for (int k = 0; k < QB; k++) begin
      dd[k+1] <= dd[k];
      rx[k+1] <= gex[k] ? rx[k] - shd[k] : rx[k];
      ry[k+1] <= gey[k] ? ry[k] - shd[k] : ry[k];
      qx[k+1] <= {qx[k][QB-2:0], gex[k]};
      qy[k+1] <= {qy[k][QB-2:0], gey[k]};
    end

    if (!(dm[QB].valid && dm[QB].hit)) begin
      meet_x <= '0;
      meet_y <= '0;
    end else if (dm[QB].use_div) begin
      meet_x <= sumx[CB-1:0];
      meet_y <= sumy[CB-1:0];
    end else begin
      meet_x <= dm[QB].px;
      meet_y <= dm[QB].py;
    end

    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      m4.valid <= 1'b0;
      m5.valid <= 1'b0;
      for (int k = 0; k <= QB; k++) begin
        dm[k].valid <= 1'b0;
      end
      done <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      m4.valid <= v3;
      m5 <= m4;
      dm[0] <= m5;
      for (int k = 0; k < QB; k++) begin
        dm[k+1] <= dm[k];
      end
      done <= dm[QB].valid;
      hit  <= dm[QB].valid && dm[QB].hit;
    end
  end

  assert property (@(posedge clk) disable iff (rst) hit |-> done)
    else $error("hit without done");
  assert property (@(posedge clk) disable iff (rst) !hit |-> (meet_x == '0 && meet_y == '0))
    else $error("nonzero point without hit");
  assert property (@(posedge clk) disable iff (rst) dm[QB].valid |=> done)
    else $error("finished word not delivered");

endmodule
